[hdl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the frequency plan dedup filter
// Transaction structs, result codes, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package fpd_pkg;

	localparam int MaxEntriesDef = 16;
	localparam int QueueDepth    = 2;
	localparam int CfgIdxW       = 3;
	localparam int CfgDataW      = 32;

	localparam logic [31:0] ResetFreqMin      = 32'd300000000;
	localparam logic [31:0] ResetFreqMax      = 32'd928000000;
	localparam logic [31:0] ResetDedupRadius  = 32'd100000;
	localparam logic [31:0] ResetBandBoundary = 32'd900000000;
	localparam logic [4:0]  ResetMaxEntries   = 5'd16;

	localparam logic [19:0] MillionHz = 20'd1000000;
	localparam logic [30:0] MhzRecip  = 31'd1125899907;
	localparam int          MhzShift  = 50;
	localparam logic [20:0] HundRecip = 21'd1717987;
	localparam int          HundShift = 34;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FREQ_MIN      = 3'd0,
		CFG_FREQ_MAX      = 3'd1,
		CFG_DEDUP_RADIUS  = 3'd2,
		CFG_BAND_BOUNDARY = 3'd3,
		CFG_MAX_ENTRIES   = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_OUT_RANGE = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_CONV1,
		BK_CONV2,
		BK_CONV3,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic [31:0] freq_min;
		logic [31:0] freq_max;
		logic [31:0] dedup_radius;
		logic [31:0] band_boundary;
		logic [4:0]  max_entries;
	} cfg_t;

	typedef struct packed {
		logic [31:0] cand_freq;
		logic        last_in_list;
	} item_t;

	typedef struct packed {
		logic [31:0] freq;
		logic        last;
		logic        in_range;
		logic        high_band;
	} q_item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  entry_index;
		logic [31:0] plan_freq;
		logic        high_band;
		logic [12:0] mhz_whole;
		logic [6:0]  mhz_hundredths;
		logic [4:0]  plan_count;
		logic        list_done;
	} result_t;

endpackage

[hdl/frequency_plan_dedup_filter.sv]
// ----------------------------------------------------------------------------
// frequency_plan_dedup_filter: scan plan builder with range and dedup checks
// A command is accepted at a rising edge with start high and busy low; item
// carries the candidate frequency and the last-in-list mark. The result of
// each transaction appears on result for exactly one cycle with done high.
// Configuration is a separate write channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and unknown indexes are ignored.
// Commands pass through a two-entry queue to the back end, which handles one
// transaction at a time. A transaction rejected as full or out of range goes
// from the idle state straight to the emit state, which shows done, and a
// transaction that finds the plan empty is stored when it is popped and
// passes the MHz conversion states CONV1, CONV2 and CONV3 before done.
// Otherwise the scan reads one entry per cycle through the store's single
// read port; a near duplicate ends the scan with done, and a transaction
// that clears the last entry is stored and passes the same conversion states.
// The back end returns to idle after each result. Queueing time adds when
// earlier transactions are still in the back end. busy is high while the
// queue is full. Reset clears the plan count, the queue and the back end, and
// loads the default register values. The receiver cannot stall.
// ----------------------------------------------------------------------------
module frequency_plan_dedup_filter
	import fpd_pkg::*;
#(
	parameter int MAX_ENTRIES = MaxEntriesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  item_t               item,
	output logic                done,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t    cfg;
	logic    q_full;
	logic    q_push;
	q_item_t q_wdata;
	logic    q_pop;
	logic    q_valid;
	q_item_t q_rdata;

	fpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fpd_front u_front (
		.start   (start),
		.busy    (busy),
		.item    (item),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	fpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	fpd_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_hund_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_ACCEPTED)) |-> (result.mhz_hundredths < 7'd100))
		else $error("MHz fraction out of range.");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_ACCEPTED)) |->
		((result.plan_freq == 32'd0) && (result.entry_index == 4'd0)))
		else $error("Rejected transaction carries a frequency or index.");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("Queue popped while empty.");

endmodule

[hdl/fpd_cfg.sv]
// ----------------------------------------------------------------------------
// fpd_cfg: configuration register file
// Holds the five plan registers and takes one write transaction per cycle.
// ----------------------------------------------------------------------------
module fpd_cfg
	import fpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_min      <= ResetFreqMin;
			cfg_q.freq_max      <= ResetFreqMax;
			cfg_q.dedup_radius  <= ResetDedupRadius;
			cfg_q.band_boundary <= ResetBandBoundary;
			cfg_q.max_entries   <= ResetMaxEntries;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FREQ_MIN:      cfg_q.freq_min      <= cfg_data;
				CFG_FREQ_MAX:      cfg_q.freq_max      <= cfg_data;
				CFG_DEDUP_RADIUS:  cfg_q.dedup_radius  <= cfg_data;
				CFG_BAND_BOUNDARY: cfg_q.band_boundary <= cfg_data;
				CFG_MAX_ENTRIES:   cfg_q.max_entries   <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/fpd_front.sv]
// ----------------------------------------------------------------------------
// fpd_front: command intake and range classification
// Accepts a candidate, checks it against the range and band boundary, and
// pushes the classified transaction into the queue.
// ----------------------------------------------------------------------------
module fpd_front
	import fpd_pkg::*;
(
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	input  cfg_t    cfg,
	input  logic    q_full,
	output logic    q_push,
	output q_item_t q_wdata
);

	assign busy   = q_full;
	assign q_push = start && !q_full;

	always_comb begin
		q_wdata.freq      = item.cand_freq;
		q_wdata.last      = item.last_in_list;
		q_wdata.in_range  = (item.cand_freq >= cfg.freq_min) &&
		                    (item.cand_freq <= cfg.freq_max);
		q_wdata.high_band = item.cand_freq >= cfg.band_boundary;
	end

endmodule

[hdl/fpd_queue.sv]
// ----------------------------------------------------------------------------
// fpd_queue: short queue between front and back
// A small register queue that lets the front take commands while the back
// works on an earlier transaction.
// ----------------------------------------------------------------------------
module fpd_queue
	import fpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t wdata,
	output logic    full,
	input  logic    pop,
	output logic    valid,
	output q_item_t rdata
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	q_item_t            slot_q [QueueDepth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [PtrW:0]      fill_q;

	assign full  = fill_q == (PtrW+1)'(QueueDepth);
	assign valid = fill_q != '0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[hdl/fpd_back.sv]
// ----------------------------------------------------------------------------
// fpd_back: plan store, duplicate scan and MHz conversion
// Pops a classified transaction, scans the plan one entry per cycle for a
// near duplicate, stores an accepted frequency and converts it to MHz.
// ----------------------------------------------------------------------------
module fpd_back
	import fpd_pkg::*;
#(
	parameter int MAX_ENTRIES = MaxEntriesDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  q_item_t q_rdata,
	output logic    q_pop,
	output logic    done,
	output result_t result
);

	localparam int CntW = $clog2(MAX_ENTRIES + 1);
	localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	back_state_t       state_q;
	back_state_t       state_d;
	q_item_t           item_q;
	status_t           status_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   scan_k_q;
	logic              cmp_vld_q;
	logic              cmp_last_q;
	logic [31:0]       rd_data_q;
	logic [3:0]        idx_q;
	logic [12:0]       whole_q;
	logic [19:0]       rem_q;
	logic [6:0]        hund_q;
	logic [31:0]       plan_mem [MAX_ENTRIES];

	logic              full_now;
	logic [31:0]       diff;
	logic              dup_hit;
	logic              scan_clear;
	logic              wr_en;
	logic [31:0]       wr_freq;
	logic [62:0]       prod_whole;
	logic [32:0]       prod_back;
	logic [40:0]       prod_hund;
	logic              acc;

	assign full_now   = (count_q >= CntW'(MAX_ENTRIES)) || (count_q >= cfg.max_entries);
	assign diff       = (item_q.freq > rd_data_q) ? item_q.freq - rd_data_q
	                                              : rd_data_q - item_q.freq;
	assign dup_hit    = cmp_vld_q && (diff < cfg.dedup_radius);
	assign scan_clear = cmp_vld_q && cmp_last_q && !dup_hit;
	assign wr_en      = ((state_q == BK_IDLE) && q_valid && !full_now &&
	                     q_rdata.in_range && (count_q == '0)) ||
	                    ((state_q == BK_SCAN) && scan_clear);
	assign wr_freq    = (state_q == BK_IDLE) ? q_rdata.freq : item_q.freq;
	assign prod_whole = 63'(item_q.freq) * 63'(MhzRecip);
	assign prod_back  = 33'(whole_q) * 33'(MillionHz);
	assign prod_hund  = 41'(rem_q) * 41'(HundRecip);
	assign acc        = status_q == ST_ACCEPTED;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (full_now || !q_rdata.in_range) begin
						state_d = BK_EMIT;
					end else if (count_q == '0) begin
						state_d = BK_CONV1;
					end else begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				if (dup_hit) begin
					state_d = BK_EMIT;
				end else if (scan_clear) begin
					state_d = BK_CONV1;
				end
			end
			BK_CONV1: state_d = BK_CONV2;
			BK_CONV2: state_d = BK_CONV3;
			BK_CONV3: state_d = BK_EMIT;
			BK_EMIT:  state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == BK_IDLE) && q_valid;
		done  = state_q == BK_EMIT;
		result.status         = status_q;
		result.entry_index    = acc ? idx_q : 4'd0;
		result.plan_freq      = acc ? item_q.freq : 32'd0;
		result.high_band      = acc && item_q.high_band;
		result.mhz_whole      = acc ? whole_q : 13'd0;
		result.mhz_hundredths = acc ? hund_q : 7'd0;
		result.plan_count     = 5'(count_q);
		result.list_done      = item_q.last;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			plan_mem[count_q[IdxW-1:0]] <= wr_freq;
		end
		rd_data_q <= plan_mem[scan_k_q[IdxW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_rdata;
			if (full_now) begin
				status_q <= ST_FULL;
			end else if (!q_rdata.in_range) begin
				status_q <= ST_OUT_RANGE;
			end else begin
				status_q <= ST_ACCEPTED;
			end
		end
		if ((state_q == BK_SCAN) && dup_hit) begin
			status_q <= ST_DUPLICATE;
		end
		if (wr_en) begin
			idx_q <= 4'(count_q);
		end
		if (state_q == BK_CONV1) begin
			whole_q <= prod_whole[MhzShift +: 13];
		end
		if (state_q == BK_CONV2) begin
			rem_q <= 20'(item_q.freq - prod_back[31:0]);
		end
		if (state_q == BK_CONV3) begin
			hund_q <= prod_hund[HundShift +: 7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			count_q    <= '0;
			scan_k_q   <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				scan_k_q  <= '0;
				cmp_vld_q <= 1'b0;
			end else if (state_q == BK_SCAN) begin
				if (scan_k_q < count_q) begin
					cmp_vld_q  <= 1'b1;
					cmp_last_q <= scan_k_q == count_q - 1'b1;
					scan_k_q   <= scan_k_q + 1'b1;
				end else begin
					cmp_vld_q <= 1'b0;
				end
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end else if ((state_q == BK_EMIT) && item_q.last) begin
				count_q <= '0;
			end
		end
	end

endmodule
